[sv/sdcc_pkg.sv]
package sdcc_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_STAGE_ONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STAGE_TWO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STAGE_THREE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAN_DELAY   = 2'd3;

	localparam logic [23:0] STAGE_ONE_RST   = 24'h231E46;
	localparam logic [23:0] STAGE_TWO_RST   = 24'h322D55;
	localparam logic [23:0] STAGE_THREE_RST = 24'h3C2850;
	localparam logic [7:0]  FAN_DELAY_RST   = 8'd6;

	localparam logic [5:0] SECS_PER_MIN  = 6'd60;
	localparam logic [5:0] MINS_PER_HOUR = 6'd60;
	localparam logic [4:0] HOURS_PER_DAY = 5'd24;

	localparam logic [1:0] STAGE_NONE  = 2'd0;
	localparam logic [1:0] STAGE_ONE   = 2'd1;
	localparam logic [1:0] STAGE_TWO   = 2'd2;
	localparam logic [1:0] STAGE_THREE = 2'd3;

	typedef struct packed {
		logic [7:0] heat;
		logic [7:0] air;
		logic [7:0] hum;
	} limits_t;

	typedef struct packed {
		limits_t    stage_one;
		limits_t    stage_two;
		limits_t    stage_three;
		logic [7:0] fan_delay;
	} cfg_t;

	typedef struct packed {
		logic       second_tick;
		logic       fan_tick;
		logic [7:0] heater_temp;
		logic [7:0] air_temp;
		logic [6:0] air_humidity;
	} item_t;

	typedef struct packed {
		logic       heater_on;
		logic       fan_on;
		logic       delay_running;
		logic [1:0] stage;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} result_t;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} tod_t;

endpackage

[sv/sdcc_cfg_regs.sv]
module sdcc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [sdcc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [sdcc_pkg::CFG_DATA_W-1:0] wr_data,
	output sdcc_pkg::cfg_t                 cfg
);
	import sdcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stage_one   <= STAGE_ONE_RST;
			cfg_q.stage_two   <= STAGE_TWO_RST;
			cfg_q.stage_three <= STAGE_THREE_RST;
			cfg_q.fan_delay   <= FAN_DELAY_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_STAGE_ONE:   cfg_q.stage_one   <= wr_data;
				CFG_STAGE_TWO:   cfg_q.stage_two   <= wr_data;
				CFG_STAGE_THREE: cfg_q.stage_three <= wr_data;
				CFG_FAN_DELAY:   cfg_q.fan_delay   <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/sdcc_clock.sv]
module sdcc_clock (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           second_tick,
	output sdcc_pkg::tod_t tod_nxt
);
	import sdcc_pkg::*;

	tod_t tod_q;
	logic [5:0] sec_inc;
	logic [5:0] min_inc;
	logic [4:0] hour_inc;

	always_comb begin
		sec_inc  = tod_q.seconds + 6'd1;
		min_inc  = tod_q.minutes + 6'd1;
		hour_inc = tod_q.hours + 5'd1;
		tod_nxt  = tod_q;
		if (second_tick) begin
			if (sec_inc >= SECS_PER_MIN) begin
				tod_nxt.seconds = '0;
				if (min_inc >= MINS_PER_HOUR) begin
					tod_nxt.minutes = '0;
					tod_nxt.hours   = (hour_inc >= HOURS_PER_DAY) ? '0 : hour_inc;
				end else begin
					tod_nxt.minutes = min_inc;
				end
			end else begin
				tod_nxt.seconds = sec_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tod_q <= '0;
		end else if (advance) begin
			tod_q <= tod_nxt;
		end
	end

endmodule

[sv/sdcc_ctrl.sv]
module sdcc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  sdcc_pkg::item_t item,
	input  sdcc_pkg::tod_t  tod,
	input  sdcc_pkg::cfg_t  cfg,
	output sdcc_pkg::result_t result
);
	import sdcc_pkg::*;

	logic [7:0] ticks_q, ticks_nxt, ticks_inc;
	logic       ready_q, ready_nxt;
	logic       enable_q, enable_nxt;
	logic       fan_q, fan_nxt;
	logic       counted, reached;
	logic [1:0] stage;
	limits_t    lim;
	logic       over;
	logic       heater;

	always_comb begin
		// stage windows, boundary tests kept as specified (gaps included)
		if (tod.hours < 5'd1 || (tod.hours == 5'd1 && tod.minutes <= 6'd35))
			stage = STAGE_ONE;
		else if ((tod.hours >= 5'd1 && tod.minutes >= 6'd36 && tod.hours < 5'd9) ||
			(tod.hours > 5'd1 && tod.hours <= 5'd9 && tod.minutes < 6'd40))
			stage = STAGE_TWO;
		else if ((tod.hours >= 5'd9 && tod.minutes >= 6'd41 && tod.hours < 5'd14) ||
			(tod.hours > 5'd9 && tod.hours <= 5'd14 && tod.minutes <= 6'd55))
			stage = STAGE_THREE;
		else
			stage = STAGE_NONE;

		case (stage)
			STAGE_ONE:   lim = cfg.stage_one;
			STAGE_TWO:   lim = cfg.stage_two;
			default:     lim = cfg.stage_three;
		endcase

		// fan delay counter first
		counted   = item.fan_tick && enable_q;
		ticks_inc = ticks_q + 8'd1;
		reached   = ticks_inc >= cfg.fan_delay;
		ticks_nxt = ticks_q;
		ready_nxt = ready_q;
		if (counted) begin
			ticks_nxt = reached ? '0 : ticks_inc;
			ready_nxt = ready_q | reached;
		end

		enable_nxt = enable_q;
		fan_nxt    = fan_q;
		heater     = 1'b1;
		over       = (item.air_temp > lim.air) || ({1'b0, item.air_humidity} > lim.hum);
		if (stage == STAGE_NONE) begin
			fan_nxt = 1'b0;
		end else begin
			heater = item.heater_temp < lim.heat;
			if (over) begin
				enable_nxt = !ready_nxt;
				if (ready_nxt)
					fan_nxt = 1'b1;
			end else begin
				enable_nxt = 1'b0;
				ready_nxt  = 1'b0;
				fan_nxt    = 1'b0;
			end
		end

		result.heater_on     = heater;
		result.fan_on        = fan_nxt;
		result.delay_running = enable_nxt;
		result.stage         = stage;
		result.hours         = tod.hours;
		result.minutes       = tod.minutes;
		result.seconds       = tod.seconds;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= '0;
			ready_q  <= 1'b0;
			enable_q <= 1'b0;
			fan_q    <= 1'b0;
		end else if (advance) begin
			ticks_q  <= ticks_nxt;
			ready_q  <= ready_nxt;
			enable_q <= enable_nxt;
			fan_q    <= fan_nxt;
		end
	end

endmodule

[sv/staged_drying_climate_controller.sv]
// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  item_t: ticks and sensor readings
// result    out        result_valid/result_stall result_t: relays, stage, clock
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data (4 registers)
//
// One beat per cycle sustained while result_stall stays low. A beat is held in
// the input stage, where the clock, stage select and fan logic update state in a
// single pass, then lands in the result register, which drives result_valid.
// Reset clears the clock, fan timer state and both pipeline valids, and loads
// the default stage limits and fan delay. A stalled result holds the input
// stage; the input stalls only when both stages hold a beat and the result is
// stalled.
module staged_drying_climate_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  sdcc_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output sdcc_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sdcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdcc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sdcc_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;
	logic    advance;
	logic    accept;
	cfg_t    cfg;
	tod_t    tod_nxt;
	result_t result_nxt;

	// the input stage moves on when the result register is free or draining
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	sdcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sdcc_clock u_clock (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.second_tick (item_s1.second_tick),
		.tod_nxt     (tod_nxt)
	);

	sdcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.tod     (tod_nxt),
		.cfg     (cfg),
		.result  (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result_nxt;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[tb/drying_climate_checker.sv]
module drying_climate_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  sdcc_pkg::item_t                 item,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  sdcc_pkg::result_t               result,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [sdcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sdcc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	import sdcc_pkg::*;

	cfg_t       regs;
	tod_t       tod;
	logic [7:0] fan_count;
	logic       fan_armed;
	logic       timer_on;
	logic       fan_lit;
	result_t    due_status[$];
	result_t    oldest;
	int         fault_count = 0;

	// print is capped, count is not
	task automatic report(input string msg);
		if (fault_count < 40) begin
			$display("%0t %s", $time, msg);
		end
		fault_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			report($sformatf("%s: got %0d, expected %0d", name, got, want));
		end
	endtask

	// windows tested exactly as the block tests them, gaps and all
	function automatic logic [1:0] stage_of(input logic [4:0] h, input logic [5:0] m);
		if (h < 1 || (h == 1 && m <= 35)) begin
			return STAGE_ONE;
		end
		if ((h >= 1 && m >= 36 && h < 9) || (h > 1 && h <= 9 && m < 40)) begin
			return STAGE_TWO;
		end
		if ((h >= 9 && m >= 41 && h < 14) || (h > 9 && h <= 14 && m <= 55)) begin
			return STAGE_THREE;
		end
		return STAGE_NONE;
	endfunction

	function automatic result_t climate_step(input item_t it);
		result_t    r;
		limits_t    lim;
		logic [1:0] st;
		logic       over;
		if (it.second_tick) begin
			if (tod.seconds == SECS_PER_MIN - 6'd1) begin
				tod.seconds = '0;
				if (tod.minutes == MINS_PER_HOUR - 6'd1) begin
					tod.minutes = '0;
					tod.hours = (tod.hours == HOURS_PER_DAY - 5'd1) ? 5'd0 : tod.hours + 5'd1;
				end else begin
					tod.minutes = tod.minutes + 6'd1;
				end
			end else begin
				tod.seconds = tod.seconds + 6'd1;
			end
		end
		// tick counts only if the timer was already running
		if (it.fan_tick && timer_on) begin
			fan_count = fan_count + 8'd1;
			if (fan_count >= regs.fan_delay) begin
				fan_count = '0;
				fan_armed = 1'b1;
			end
		end
		st = stage_of(tod.hours, tod.minutes);
		r.heater_on = 1'b1;
		if (st == STAGE_NONE) begin
			fan_lit = 1'b0;
		end else begin
			case (st)
				STAGE_ONE: lim = regs.stage_one;
				STAGE_TWO: lim = regs.stage_two;
				default:   lim = regs.stage_three;
			endcase
			r.heater_on = it.heater_temp < lim.heat;
			over = (it.air_temp > lim.air) || ({1'b0, it.air_humidity} > lim.hum);
			if (over) begin
				timer_on = 1'b1;
				if (fan_armed) begin
					timer_on = 1'b0;
					fan_lit  = 1'b1;
				end
			end else begin
				timer_on  = 1'b0;
				fan_armed = 1'b0;
				fan_lit   = 1'b0;
			end
		end
		r.fan_on        = fan_lit;
		r.delay_running = timer_on;
		r.stage         = st;
		r.hours         = tod.hours;
		r.minutes       = tod.minutes;
		r.seconds       = tod.seconds;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs      = {STAGE_ONE_RST, STAGE_TWO_RST, STAGE_THREE_RST, FAN_DELAY_RST};
			tod       = '0;
			fan_count = '0;
			fan_armed = 1'b0;
			timer_on  = 1'b0;
			fan_lit   = 1'b0;
			due_status.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STAGE_ONE:   regs.stage_one   = cfg_data;
					CFG_STAGE_TWO:   regs.stage_two   = cfg_data;
					CFG_STAGE_THREE: regs.stage_three = cfg_data;
					CFG_FAN_DELAY:   regs.fan_delay   = cfg_data[7:0];
					default: ;
				endcase
			end
			// results first: a beat taken at this edge cannot already have its result
			if (result_valid && !result_stall) begin
				if (due_status.size() == 0) begin
					report("result beat with nothing due");
				end else begin
					oldest = due_status.pop_front();
					check_field("heater_on", 8'(result.heater_on), 8'(oldest.heater_on));
					check_field("fan_on", 8'(result.fan_on), 8'(oldest.fan_on));
					check_field("delay_running", 8'(result.delay_running),
						8'(oldest.delay_running));
					check_field("stage", 8'(result.stage), 8'(oldest.stage));
					check_field("hours", 8'(result.hours), 8'(oldest.hours));
					check_field("minutes", 8'(result.minutes), 8'(oldest.minutes));
					check_field("seconds", 8'(result.seconds), 8'(oldest.seconds));
				end
			end
			if (item_valid && !item_stall) begin
				due_status.push_back(climate_step(item));
			end
		end
		outstanding <= due_status.size();
		mismatches  <= fault_count;
	end

endmodule

[tb/tb_staged_drying_climate_controller.sv]
module tb_staged_drying_climate_controller;
	import sdcc_pkg::*;

	// Worst case is a full gap on the sender and a full stall on the receiver for
	// every one of about 1000 beats, plus register writes and drains; the limit
	// sits several times above that.
	localparam int CYCLE_LIMIT = 200_000;

	// Shapes of sensor reading used by the random stimulus
	typedef enum int {READ_MIXED, READ_HOT, READ_CALM, READ_BORDER} reading_mode_t;

	// Settings styles: plausible, all-zero limits, all-ones limits, anything
	typedef enum int {SET_PLAUSIBLE, SET_ZERO, SET_FULL, SET_WILD} settings_t;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	item_t                 item_beat;
	logic                  result_valid;
	logic                  result_stall;
	result_t               result_beat;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int      mismatches;
	int      outstanding;
	int      cycle_count = 0;
	bit      idle_on     = 1'b1;

	// Limits as last written, so that border readings can be aimed at them
	limits_t lim_copy [3];

	staged_drying_climate_controller u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_beat),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	drying_climate_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_beat),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("staged_drying_climate_controller: mismatch");
			$finish;
		end
	end

	// Receiver: per beat, raise stall (only while idling is on), then drop it until a
	// beat goes through. Only one assignment to result_stall per falling edge.
	initial begin
		int gap;
		result_stall = 1'b0;
		forever begin
			gap = idle_on ? $urandom_range(0, 8) : 0;
			if (gap != 0) begin
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	// One config write; the copy of the limits follows it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_STAGE_ONE:   lim_copy[0] = val;
			CFG_STAGE_TWO:   lim_copy[1] = val;
			CFG_STAGE_THREE: lim_copy[2] = val;
			default: ;
		endcase
	endtask

	// Writes all four registers. Fan delay carries junk in the unused upper bits.
	task automatic apply_settings(input settings_t style);
		logic [CFG_IDX_W-1:0] stage_reg [3];
		limits_t              l;
		logic [7:0]           d;
		stage_reg = '{CFG_STAGE_ONE, CFG_STAGE_TWO, CFG_STAGE_THREE};
		for (int i = 0; i < 3; i++) begin
			case (style)
				SET_PLAUSIBLE: l = {8'($urandom_range(20, 90)), 8'($urandom_range(20, 60)),
					8'($urandom_range(40, 95))};
				SET_ZERO:      l = '0;
				SET_FULL:      l = '1;
				default:       l = limits_t'($urandom);
			endcase
			write_reg(stage_reg[i], l);
		end
		case (style)
			SET_PLAUSIBLE: d = 8'($urandom_range(1, 12));
			SET_ZERO:      d = 8'd1;
			SET_FULL:      d = 8'd255;
			default:       d = 8'($urandom_range(1, 255));
		endcase
		write_reg(CFG_FAN_DELAY, {16'($urandom), d});
	endtask

	// Sender: idle with junk on the bus while idling is on, then the beat, held until taken
	task automatic push_item(input item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
			item_beat  <= item_t'($urandom);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item_beat  <= it;
		do @(posedge clk); while (item_stall);
	endtask

	// Block is idle once every result is home, then the pipeline is left to settle
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [7:0] beside_limit(input logic [7:0] v, input int ceiling);
		int x;
		x = int'(v) + $urandom_range(0, 2) - 1;
		if (x < 0) begin
			x = 0;
		end
		if (x > ceiling) begin
			x = ceiling;
		end
		return x[7:0];
	endfunction

	// Hot readings sit above any plausible limit, calm ones below; border ones
	// straddle one stage's limits (which stage is left to chance).
	function automatic item_t make_reading(input reading_mode_t mode, input int tick_pct);
		item_t   it;
		limits_t l;
		l = lim_copy[$urandom_range(0, 2)];
		it.second_tick  = ($urandom_range(0, 99) < tick_pct);
		it.fan_tick     = 1'($urandom_range(0, 1));
		it.heater_temp  = 8'($urandom);
		it.air_temp     = 8'($urandom);
		it.air_humidity = 7'($urandom_range(0, 100));
		case (mode)
			READ_HOT: begin
				it.air_temp = 8'($urandom_range(200, 255));
			end
			READ_CALM: begin
				it.air_temp     = 8'($urandom_range(0, 19));
				it.air_humidity = 7'($urandom_range(0, 39));
			end
			READ_BORDER: begin
				it.heater_temp  = beside_limit(l.heat, 255);
				it.air_temp     = beside_limit(l.air, 255);
				it.air_humidity = 7'(beside_limit(l.hum, 100));
			end
			default: ;
		endcase
		return it;
	endfunction

	// Runs of 1..64 beats share a reading shape and an idling choice, so hot
	// spells last long enough for the fan delay to run out.
	task automatic run_items(input int count, input int tick_pct, input int idle_pct);
		int            left;
		reading_mode_t mode;
		left = 0;
		mode = READ_MIXED;
		for (int i = 0; i < count; i++) begin
			if (left == 0) begin
				left    = $urandom_range(1, 64);
				mode    = reading_mode_t'($urandom_range(0, 3));
				idle_on = ($urandom_range(0, 99) < idle_pct);
			end
			push_item(make_reading(mode, tick_pct));
			left--;
		end
	endtask

	initial begin
		settings_t style;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item_beat  = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_STAGE_ONE;
		cfg_data   = '0;
		lim_copy   = '{STAGE_ONE_RST, STAGE_TWO_RST, STAGE_THREE_RST};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, on reset limits (35/30/70, delay 6) just after midnight: stage one.
		// Field extremes, each limit met and just crossed, a full fan delay with the
		// fan coming on, the armed fan staying on, then a calm reading clearing it.
		push_item(item_t'{1'b0, 1'b0, 8'd0, 8'd0, 7'd0});
		push_item(item_t'{1'b1, 1'b1, 8'd255, 8'd255, 7'd100});
		repeat (6) push_item(item_t'{1'b0, 1'b1, 8'd34, 8'd31, 7'd0});
		push_item(item_t'{1'b0, 1'b1, 8'd35, 8'd31, 7'd0});
		push_item(item_t'{1'b0, 1'b0, 8'd35, 8'd30, 7'd70});
		push_item(item_t'{1'b0, 1'b0, 8'd0, 8'd30, 7'd71});
		push_item(item_t'{1'b1, 1'b0, 8'd255, 8'd0, 7'd64});
		push_item(item_t'{1'b0, 1'b1, 8'd36, 8'd0, 7'd100});
		push_item(item_t'{1'b1, 1'b1, 8'd128, 8'd128, 7'd1});
		push_item(item_t'{1'b1, 1'b1, 8'd127, 8'd29, 7'd99});
		push_item(item_t'{1'b0, 1'b1, 8'd1, 8'd1, 7'd63});
		settle();

		// Random, heavy idling, every settings style including both extremes
		for (int blk = 0; blk < 5; blk++) begin
			style = settings_t'(blk % 4);
			apply_settings(style);
			run_items(100, 50, 75);
			settle();
		end

		// Tick-heavy runs: mostly second ticks, so the clock walks on through the
		// minutes and second wraps. New settings every run.
		for (int chunk = 0; chunk < 4; chunk++) begin
			if (chunk % 9 == 4) begin
				style = SET_ZERO;
			end else if (chunk % 9 == 7) begin
				style = SET_FULL;
			end else if (chunk % 5 == 2) begin
				style = SET_WILD;
			end else begin
				style = SET_PLAUSIBLE;
			end
			apply_settings(style);
			run_items(120, 88, 25);
			settle();
		end

		if (mismatches == 0) begin
			$display("staged_drying_climate_controller: match");
		end else begin
			$display("staged_drying_climate_controller: mismatch");
		end
		$finish;
	end

endmodule
